[rtl/assert_macros.svh]
// Assertion macros used by the RTL top level of the event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, when true, implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

[rtl/tseq_pkg.sv]
// Types, codes and helper functions of the timestamped event queue.
package tseq_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_COLLECT = 2'd2;

  // Result kinds of an output beat.
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EVENT   = 2'd1;
  localparam logic [1:0] KIND_NOTHING = 2'd2;

  // Event type codes.
  localparam logic [1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [1:0] EV_NOTE_OFF = 2'd1;
  localparam logic [1:0] EV_PROGRAM  = 2'd2;

  // Stored entry: taken flag, packed payload and due time.
  typedef struct packed {
    logic        taken;
    logic [6:0]  velocity;
    logic [6:0]  note;
    logic [7:0]  track;
    logic [1:0]  ev_type;
    logic [63:0] due;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // One result beat as held in the output register.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic        was_dropped;
    logic [1:0]  out_type;
    logic [7:0]  out_track;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [15:0] block_offset;
    logic        was_overdue;
    logic        was_clamped;
    logic        last;
  } result_t;

  // Ordering rank on equal times: note off, then program change, then the rest.
  function automatic logic [1:0] rank_of(input logic [1:0] ev_type);
    logic [1:0] r;
    unique case (ev_type)
      EV_NOTE_OFF: r = 2'd0;
      EV_PROGRAM:  r = 2'd1;
      default:     r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

[rtl/tseq_if.sv]
// Valid/ready channel interfaces for input and result beats.
interface tseq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] due_time;
  logic [1:0]  event_type;
  logic [7:0]  track;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [63:0] block_start;
  logic [15:0] frame_count;
  logic [6:0]  event_limit;

  modport source (output valid, operation, due_time, event_type, track, note, velocity,
                  block_start, frame_count, event_limit, input ready);
  modport sink (input valid, operation, due_time, event_type, track, note, velocity,
                block_start, frame_count, event_limit, output ready);
endinterface

interface tseq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        was_dropped;
  logic [1:0]  out_type;
  logic [7:0]  out_track;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic [15:0] block_offset;
  logic        was_overdue;
  logic        was_clamped;
  logic        last;

  modport source (output valid, result_kind, was_dropped, out_type, out_track, out_note,
                  out_velocity, block_offset, was_overdue, was_clamped, last, input ready);
  modport sink (input valid, result_kind, was_dropped, out_type, out_track, out_note,
                out_velocity, block_offset, was_overdue, was_clamped, last, output ready);
endinterface

[rtl/timestamped_event_queue.sv]
// Top level of the timestamped event queue: control, scan, compaction and result register.
//
//   channel | direction | beat
//   in_i    | sink      | one operation: push, clear or collect
//   out_o   | source    | one result: push acknowledge, collected event or nothing found
//
// A push gives one acknowledge beat.
// A collect runs one full read pass through the entry memory for each selection,
// then a final pass that compacts the survivors if anything was taken. The entry
// memory has a single read port.
// Reset empties the queue at once; the memory itself needs no clearing.
// A stalled result beat halts the collect until it is taken.
`include "assert_macros.svh"

module timestamped_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 256,
  parameter int unsigned MAX_COLLECT = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  tseq_in_if.sink    in_i,
  tseq_out_if.source out_o
);
  import tseq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = AW + 1;
  localparam logic [FW-1:0] DepthVal = FW'(QUEUE_DEPTH);
  localparam logic [6:0] MaxCollect = 7'(MAX_COLLECT);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_PICK    = 3'd2;
  localparam logic [2:0] S_FINAL   = 3'd3;
  localparam logic [2:0] S_COMPACT = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] rd_idx_q, rd_idx_d;
  logic [FW-1:0] wr_idx_q, wr_idx_d;
  logic          dv_q;
  logic [AW-1:0] didx_q;
  logic [6:0]    count_q, count_d;
  logic [6:0]    limit_q, limit_d;
  logic [63:0]   start_q, start_d;
  logic [15:0]   frames_q, frames_d;
  logic [64:0]   end_q, end_d;
  logic          found_q, found_d;
  entry_t        best_q, best_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic          pend_valid_q, pend_valid_d;
  result_t       pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;

  logic             mem_wr_en, mem_rd_en;
  logic [AW-1:0]    mem_wr_addr;
  entry_t           mem_wr_data, ent;
  logic [EntryW-1:0] mem_rdata;

  logic        out_free, accept;
  logic [15:0] frames_eff;
  logic [6:0]  limit_sat;
  logic        ent_due, ent_better;
  logic        overdue, clamped;
  logic [63:0] diff, off0;
  result_t     new_res;

  tseq_mem #(.Depth(QUEUE_DEPTH), .Width(EntryW)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (rd_idx_q[AW-1:0]),
    .rd_data_o (mem_rdata)
  );

  assign ent      = entry_t'(mem_rdata);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;

  assign frames_eff = (in_i.frame_count == 16'd0) ? 16'd1 : in_i.frame_count;
  assign limit_sat  = (in_i.event_limit > MaxCollect) ? MaxCollect : in_i.event_limit;
  assign mem_rd_en  = ((state_q == S_SCAN) || (state_q == S_COMPACT)) && (rd_idx_q < fill_q);

  // Due test and ordering of the entry just read against the best so far.
  assign ent_due    = {1'b0, ent.due} < end_q;
  assign ent_better = !found_q ||
                      ({ent.due, rank_of(ent.ev_type)} < {best_q.due, rank_of(best_q.ev_type)});

  // Offset of the selected entry inside the block.
  assign overdue = best_q.due < start_q;
  assign diff    = best_q.due - start_q;
  assign off0    = overdue ? 64'd0 : diff;
  assign clamped = off0 >= {48'd0, frames_q};

  always_comb begin
    new_res              = '0;
    new_res.result_kind  = KIND_EVENT;
    new_res.out_type     = best_q.ev_type;
    new_res.out_track    = best_q.track;
    new_res.out_note     = best_q.note;
    new_res.out_velocity = best_q.velocity;
    new_res.block_offset = clamped ? (frames_q - 16'd1) : off0[15:0];
    new_res.was_overdue  = overdue;
    new_res.was_clamped  = clamped;
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    count_d      = count_q;
    limit_d      = limit_q;
    start_d      = start_q;
    frames_d     = frames_q;
    end_d        = end_q;
    found_d      = found_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = fill_q[AW-1:0];
    mem_wr_data  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_i.operation)
            OP_PUSH: begin
              out_valid_d     = 1'b1;
              out_d           = '0;
              out_d.result_kind = KIND_ACK;
              out_d.last      = 1'b1;
              if (fill_q >= DepthVal) begin
                out_d.was_dropped = 1'b1;
              end else begin
                mem_wr_en            = 1'b1;
                mem_wr_data.taken    = 1'b0;
                mem_wr_data.velocity = in_i.velocity;
                mem_wr_data.note     = in_i.note;
                mem_wr_data.track    = in_i.track;
                mem_wr_data.ev_type  = in_i.event_type;
                mem_wr_data.due      = in_i.due_time;
                fill_d               = fill_q + FW'(1);
              end
            end
            OP_CLEAR: begin
              fill_d = '0;
            end
            OP_COLLECT: begin
              start_d      = in_i.block_start;
              frames_d     = frames_eff;
              end_d        = {1'b0, in_i.block_start} + {49'd0, frames_eff};
              limit_d      = limit_sat;
              count_d      = '0;
              pend_valid_d = 1'b0;
              found_d      = 1'b0;
              rd_idx_d     = '0;
              state_d      = (limit_sat == 7'd0) ? S_FINAL : S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      // One pass over the stored entries keeps the best due candidate.
      S_SCAN: begin
        if (mem_rd_en) begin
          rd_idx_d = rd_idx_q + FW'(1);
        end
        if (dv_q && !ent.taken && ent_due && ent_better) begin
          found_d    = 1'b1;
          best_d     = ent;
          best_idx_d = didx_q;
        end
        if (!mem_rd_en && !dv_q) begin
          state_d = S_PICK;
        end
      end

      // Hand on the previous pick, hold the new one and mark it taken; with no pick, go to the final beat.
      S_PICK: begin
        if (!found_q) begin
          state_d = S_FINAL;
        end else if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
          end
          pend_valid_d      = 1'b1;
          pend_d            = new_res;
          mem_wr_en         = 1'b1;
          mem_wr_addr       = best_idx_q;
          mem_wr_data       = best_q;
          mem_wr_data.taken = 1'b1;
          count_d           = count_q + 7'd1;
          found_d           = 1'b0;
          rd_idx_d          = '0;
          state_d           = (count_q + 7'd1 == limit_q) ? S_FINAL : S_SCAN;
        end
      end

      // Final beat of the collect, then compaction if anything was taken.
      S_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (pend_valid_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d             = '0;
            out_d.result_kind = KIND_NOTHING;
            out_d.last        = 1'b1;
          end
          pend_valid_d = 1'b0;
          rd_idx_d     = '0;
          wr_idx_d     = '0;
          state_d      = (count_q == 7'd0) ? S_IDLE : S_COMPACT;
        end
      end

      // Survivors move down in order; taken entries are dropped.
      S_COMPACT: begin
        if (mem_rd_en) begin
          rd_idx_d = rd_idx_q + FW'(1);
        end
        if (dv_q && !ent.taken) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_idx_q[AW-1:0];
          mem_wr_data = ent;
          wr_idx_d    = wr_idx_q + FW'(1);
        end
        if (!mem_rd_en && !dv_q) begin
          fill_d  = wr_idx_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      dv_q         <= 1'b0;
      count_q      <= '0;
      limit_q      <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      rd_idx_q     <= rd_idx_d;
      wr_idx_q     <= wr_idx_d;
      dv_q         <= mem_rd_en;
      count_q      <= count_d;
      limit_q      <= limit_d;
      found_q      <= found_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    didx_q     <= rd_idx_q[AW-1:0];
    start_q    <= start_d;
    frames_q   <= frames_d;
    end_q      <= end_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_q.result_kind;
  assign out_o.was_dropped  = out_q.was_dropped;
  assign out_o.out_type     = out_q.out_type;
  assign out_o.out_track    = out_q.out_track;
  assign out_o.out_note     = out_q.out_note;
  assign out_o.out_velocity = out_q.out_velocity;
  assign out_o.block_offset = out_q.block_offset;
  assign out_o.was_overdue  = out_q.was_overdue;
  assign out_o.was_clamped  = out_q.was_clamped;
  assign out_o.last         = out_q.last;

  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= DepthVal, "queue fill beyond depth")
  `ASSERT_IMPLIES(a_scan_count, clk_i, rst_ni, state_q == S_SCAN, count_q < limit_q,
                  "scan running with the collect limit reached")
  `ASSERT_IMPLIES(a_compact_order, clk_i, rst_ni, state_q == S_COMPACT, wr_idx_q <= rd_idx_q,
                  "compaction write overtook the read pointer")
  `ASSERT_IMPLIES(a_pick_marks, clk_i, rst_ni, state_q == S_PICK && found_q && mem_wr_en,
                  mem_wr_data.taken, "selected entry written back without its taken flag")

endmodule

[rtl/tseq_mem.sv]
// Entry memory: one write port, one registered read port.
module tseq_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 89,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, enabled by rd_en_i.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench of the timestamped event queue: directed, fill, stall and random beats.
`timescale 1ns / 1ps

module tb;
  import tseq_pkg::*;

  localparam int unsigned QDEPTH  = 256;
  localparam int unsigned QCOLLECT = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] EV_SPARE  = 2'd3;

  // One input beat as the sender drives it.
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] due_time;
    logic [1:0]  event_type;
    logic [7:0]  track;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [63:0] block_start;
    logic [15:0] frame_count;
    logic [6:0]  event_limit;
  } in_beat_t;

  logic clk;
  logic rst_n;

  tseq_in_if  in_ch ();
  tseq_out_if out_ch ();

  timestamped_event_queue dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // Shadow copy of the queue contents.
  logic [63:0] shadow_due [QDEPTH];
  logic [1:0]  shadow_type [QDEPTH];
  logic [21:0] shadow_data [QDEPTH];
  int unsigned shadow_fill;

  result_t     pending_results [$];
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;
  logic [63:0] block_cursor;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung run.
  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Ordering rank on equal due times.
  function automatic int order_rank(input logic [1:0] ev);
    if (ev == EV_NOTE_OFF) return 0;
    if (ev == EV_PROGRAM) return 1;
    return 2;
  endfunction

  // Work out the results that one accepted beat causes and update the shadow queue.
  task automatic predict_results(input in_beat_t b);
    result_t     r;
    logic [63:0] frames;
    logic [63:0] off;
    logic [63:0] d;
    int unsigned limit;
    int unsigned count;
    int unsigned sel;
    int unsigned w;
    bit          found;
    bit          picked [QDEPTH];
    case (b.operation)
      OP_PUSH: begin
        r = '0;
        if (shadow_fill >= QDEPTH) begin
          r.was_dropped = 1'b1;
        end else begin
          shadow_due[shadow_fill]  = b.due_time;
          shadow_type[shadow_fill] = b.event_type;
          shadow_data[shadow_fill] = {b.velocity, b.note, b.track};
          shadow_fill++;
        end
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      OP_CLEAR: begin
        shadow_fill = 0;
      end
      OP_COLLECT: begin
        frames = (b.frame_count == 16'd0) ? 64'd1 : 64'(b.frame_count);
        limit  = (b.event_limit > QCOLLECT) ? QCOLLECT : b.event_limit;
        count  = 0;
        foreach (picked[i]) picked[i] = 1'b0;
        while (count < limit) begin
          found = 1'b0;
          sel   = 0;
          for (int unsigned i = 0; i < shadow_fill; i++) begin
            d = shadow_due[i];
            if (picked[i]) continue;
            if (d >= b.block_start && (d - b.block_start) >= frames) continue;
            if (!found || d < shadow_due[sel] || (d == shadow_due[sel] &&
                order_rank(shadow_type[i]) < order_rank(shadow_type[sel]))) begin
              found = 1'b1;
              sel   = i;
            end
          end
          if (!found) break;
          r = '0;
          r.result_kind = KIND_EVENT;
          r.out_type    = shadow_type[sel];
          {r.out_velocity, r.out_note, r.out_track} = shadow_data[sel];
          d = shadow_due[sel];
          if (d < b.block_start) begin
            off = 64'd0;
            r.was_overdue = 1'b1;
          end else begin
            off = d - b.block_start;
          end
          if (off >= frames) begin
            off = frames - 64'd1;
            r.was_clamped = 1'b1;
          end
          r.block_offset = off[15:0];
          pending_results.push_back(r);
          picked[sel] = 1'b1;
          count++;
        end
        // Survivors close up and keep their order.
        w = 0;
        for (int unsigned i = 0; i < shadow_fill; i++) begin
          if (picked[i]) continue;
          shadow_due[w]  = shadow_due[i];
          shadow_type[w] = shadow_type[i];
          shadow_data[w] = shadow_data[i];
          w++;
        end
        shadow_fill = w;
        if (count == 0) begin
          r = '0;
          r.result_kind = KIND_NOTHING;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offer one beat after a random gap and wait until it is accepted.
  task automatic send_beat(input in_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.operation    = b.operation;
    in_ch.due_time     = b.due_time;
    in_ch.event_type   = b.event_type;
    in_ch.track        = b.track;
    in_ch.note         = b.note;
    in_ch.velocity     = b.velocity;
    in_ch.block_start  = b.block_start;
    in_ch.frame_count  = b.frame_count;
    in_ch.event_limit  = b.event_limit;
    do @(posedge clk); while (!in_ch.ready);
    predict_results(b);
  endtask

  function automatic in_beat_t push_beat(input logic [63:0] due, input logic [1:0] ev,
                                         input logic [7:0] trk, input logic [6:0] nt,
                                         input logic [6:0] vel);
    in_beat_t b;
    b = '0;
    b.operation = OP_PUSH;
    b.due_time = due;
    b.event_type = ev;
    b.track = trk;
    b.note = nt;
    b.velocity = vel;
    return b;
  endfunction

  function automatic in_beat_t collect_beat(input logic [63:0] start, input logic [15:0] frames,
                                            input logic [6:0] most);
    in_beat_t     b;
    logic [223:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    b = noise[$bits(in_beat_t)-1:0];
    b.operation = OP_COLLECT;
    b.block_start = start;
    b.frame_count = frames;
    b.event_limit = most;
    return b;
  endfunction

  function automatic in_beat_t plain_beat(input logic [1:0] op);
    in_beat_t     b;
    logic [223:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    b = noise[$bits(in_beat_t)-1:0];
    b.operation = op;
    return b;
  endfunction

  // Result receiver: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected, kind %0d", out_ch.result_kind);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, out_ch.result_kind);
          fail_count++;
        end
        if (out_ch.was_dropped !== want.was_dropped) begin
          $error("was_dropped: expected %0d, got %0d", want.was_dropped, out_ch.was_dropped);
          fail_count++;
        end
        if (out_ch.out_type !== want.out_type) begin
          $error("out_type: expected %0d, got %0d", want.out_type, out_ch.out_type);
          fail_count++;
        end
        if (out_ch.out_track !== want.out_track) begin
          $error("out_track: expected %0d, got %0d", want.out_track, out_ch.out_track);
          fail_count++;
        end
        if (out_ch.out_note !== want.out_note) begin
          $error("out_note: expected %0d, got %0d", want.out_note, out_ch.out_note);
          fail_count++;
        end
        if (out_ch.out_velocity !== want.out_velocity) begin
          $error("out_velocity: expected %0d, got %0d", want.out_velocity, out_ch.out_velocity);
          fail_count++;
        end
        if (out_ch.block_offset !== want.block_offset) begin
          $error("block_offset: expected %0d, got %0d", want.block_offset, out_ch.block_offset);
          fail_count++;
        end
        if (out_ch.was_overdue !== want.was_overdue) begin
          $error("was_overdue: expected %0d, got %0d", want.was_overdue, out_ch.was_overdue);
          fail_count++;
        end
        if (out_ch.was_clamped !== want.was_clamped) begin
          $error("was_clamped: expected %0d, got %0d", want.was_clamped, out_ch.was_clamped);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Extremes of the fields, every operation and the corner cases of a collect.
  task automatic test_directed();
    send_beat(collect_beat(64'd0, 16'd0, 7'd127));
    send_beat(push_beat(64'd0, EV_NOTE_ON, 8'd0, 7'd0, 7'd0));
    send_beat(push_beat('1, EV_SPARE, 8'd255, 7'd127, 7'd127));
    send_beat(plain_beat(OP_UNUSED));
    send_beat(collect_beat(64'd0, 16'd5, 7'd0));
    send_beat(collect_beat(64'd0, 16'd0, 7'd1));
    // Equal times: note off, program change, then the other types, oldest first.
    send_beat(push_beat(64'd100, EV_NOTE_ON, 8'd1, 7'd60, 7'd90));
    send_beat(push_beat(64'd100, EV_SPARE, 8'd2, 7'd61, 7'd91));
    send_beat(push_beat(64'd100, EV_PROGRAM, 8'd3, 7'd5, 7'd0));
    send_beat(push_beat(64'd100, EV_NOTE_OFF, 8'd4, 7'd60, 7'd0));
    send_beat(push_beat(64'd100, EV_NOTE_ON, 8'd5, 7'd62, 7'd92));
    send_beat(push_beat(64'd40, EV_NOTE_OFF, 8'd6, 7'd63, 7'd0));
    // Overdue beat and a partial collect that leaves survivors.
    send_beat(collect_beat(64'd90, 16'd11, 7'd3));
    send_beat(collect_beat(64'd90, 16'd65535, 7'd127));
    // Block end past the top of time.
    send_beat(push_beat(64'hFFFF_FFFF_FFFF_FFF0, EV_PROGRAM, 8'd7, 7'd1, 7'd1));
    send_beat(collect_beat(64'hFFFF_FFFF_FFFF_FF00, 16'hFFFF, 7'd64));
    send_beat(push_beat(64'd7, EV_NOTE_ON, 8'd8, 7'd2, 7'd2));
    send_beat(plain_beat(OP_CLEAR));
    send_beat(collect_beat(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 7'd64));
  endtask

  // Fill the queue past its depth, then collect with a saturated count.
  task automatic test_full_queue();
    send_beat(plain_beat(OP_CLEAR));
    for (int i = 0; i < QDEPTH + 3; i++) begin
      send_beat(push_beat(64'($urandom_range(500)), 2'($urandom_range(3)), 8'($urandom),
                          7'($urandom), 7'($urandom)));
    end
    send_beat(collect_beat(64'd100, 16'd300, 7'd100));
    send_beat(collect_beat(64'd0, 16'd0, 7'd127));
    send_beat(plain_beat(OP_CLEAR));
  endtask

  // Hold results back long enough that the block stalls its input.
  task automatic test_backpressure();
    hold_request = 400;
    for (int i = 0; i < 30; i++) begin
      send_beat(push_beat(64'(i * 3), EV_NOTE_ON, 8'(i), 7'(i), 7'(i)));
    end
    send_beat(collect_beat(64'd0, 16'd200, 7'd40));
  endtask

  // Mostly well-formed pushes and collects around a moving block, with clears and some noise.
  task automatic test_random(input int unsigned beats);
    in_beat_t    b;
    int unsigned pick;
    logic [15:0] frames;
    for (int unsigned n = 0; n < beats; n++) begin
      pick = $urandom_range(99);
      if (shadow_fill > 40 || pick < 5) begin
        send_beat(plain_beat(OP_CLEAR));
      end else if (pick < 8) begin
        send_beat(plain_beat(OP_UNUSED));
      end else if (pick < 68) begin
        b = push_beat(block_cursor + 64'($urandom_range(3300)) - 64'd300,
                      2'($urandom_range(3)), 8'($urandom), 7'($urandom), 7'($urandom));
        if ($urandom_range(9) == 0) b.due_time = {$urandom, $urandom};
        send_beat(b);
      end else begin
        frames = 16'($urandom_range(64, 1024));
        if ($urandom_range(7) == 0) frames = 16'($urandom);
        if ($urandom_range(15) == 0) frames = 16'd0;
        b = collect_beat(block_cursor, frames, 7'($urandom_range(1, 16)));
        if ($urandom_range(7) == 0) b.event_limit = 7'($urandom);
        if ($urandom_range(19) == 0) begin
          b.block_start = {$urandom, $urandom};
          block_cursor  = b.block_start;
        end
        send_beat(b);
        block_cursor = block_cursor + 64'(frames);
      end
    end
  endtask

  // Main sequence.
  initial begin
    fail_count    = 0;
    shadow_fill   = 0;
    hold_request  = 0;
    block_cursor  = 64'd1000;
    send_idle_pct = 9;
    recv_idle_pct = 45;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PUSH;
    in_ch.due_time = '0;
    in_ch.event_type = EV_NOTE_ON;
    in_ch.track = '0;
    in_ch.note = '0;
    in_ch.velocity = '0;
    in_ch.block_start = '0;
    in_ch.frame_count = '0;
    in_ch.event_limit = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_queue();
    test_random(73);
    send_idle_pct = 45;
    recv_idle_pct = 9;
    test_backpressure();
    test_random(73);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(74);

    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tseq_pkg.sv
rtl/tseq_if.sv
rtl/tseq_mem.sv
rtl/timestamped_event_queue.sv
tb/tb.sv
